// ===== rtl/pee_pkg.sv =====
// Package for the prefix expression evaluator: token, queue entry and status types.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package pee_pkg;

  // Character classes decided by the front end
  typedef enum logic [2:0] {
    K_SPACE = 3'd0,
    K_OPND  = 3'd1,
    K_ADD   = 3'd2,
    K_SUB   = 3'd3,
    K_MUL   = 3'd4,
    K_DIV   = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_COUNT = 3'd1,
    ST_UNDER = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_LONG  = 3'd4
  } status_t;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // One classified character as stored in the character buffer
  typedef struct packed {
    kind_t      kind;
    logic [7:0] sym;
  } token_t;

  // One entry of the queue between front and back
  typedef struct packed {
    token_t tok;
    logic   last;
  } q_item_t;

  // Queue depth (power of two) and pointer width
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

endpackage

// ===== rtl/pee_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module pee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pee_queue.sv =====
// Short FIFO between the front end and the evaluation back end.
// Depends on pee_pkg (q_item_t, QDEPTH, QAW).
`timescale 1ns / 1ps

module pee_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  pee_pkg::q_item_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output pee_pkg::q_item_t pop_data
);

  localparam int CNTW = $clog2(pee_pkg::QDEPTH + 1);

  pee_pkg::q_item_t                entries [pee_pkg::QDEPTH];
  logic [pee_pkg::QAW-1:0]         wptr;
  logic [pee_pkg::QAW-1:0]         rptr;
  logic [CNTW-1:0]                 fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (fill != CNTW'(pee_pkg::QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill level; pointers wrap since the depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + pee_pkg::QAW'(1);
      if (do_pop)  rptr <= rptr + pee_pkg::QAW'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNTW'(1);
        2'b01:   fill <= fill - CNTW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/pee_front.sv =====
// Front end: accepts characters, classifies them and queues them for the back end.
// Depends on pee_pkg and pee_queue.
`timescale 1ns / 1ps

module pee_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       symbol,
  input  logic             last,
  output logic             tok_valid,
  input  logic             tok_ready,
  output pee_pkg::q_item_t tok_data
);

  pee_pkg::q_item_t item;

  // Classify the incoming character
  always_comb begin
    item.tok.sym = symbol;
    item.last    = last;
    unique case (symbol)
      pee_pkg::CH_PLUS:  item.tok.kind = pee_pkg::K_ADD;
      pee_pkg::CH_MINUS: item.tok.kind = pee_pkg::K_SUB;
      pee_pkg::CH_STAR:  item.tok.kind = pee_pkg::K_MUL;
      pee_pkg::CH_SLASH: item.tok.kind = pee_pkg::K_DIV;
      pee_pkg::CH_SPACE: item.tok.kind = pee_pkg::K_SPACE;
      default:           item.tok.kind = pee_pkg::K_OPND;
    endcase
  end

  pee_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (item),
    .pop_valid  (tok_valid),
    .pop_ready  (tok_ready),
    .pop_data   (tok_data)
  );

endmodule

// ===== rtl/pee_divider.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
`timescale 1ns / 1ps

module pee_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] mag_b;
  logic        neg;
  logic [32:0] trial;
  logic        fits;
  logic [32:0] diff;

  // One restoring step
  assign trial = {rem, quo[31]};
  assign fits  = (trial >= {1'b0, mag_b});
  assign diff  = trial - {1'b0, mag_b};

  assign quotient = neg ? (32'd0 - quo) : quo;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
      mag_b <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg   <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      rem <= fits ? diff[31:0] : trial[31:0];
      quo <= {quo[30:0], fits};
    end
  end

endmodule

// ===== rtl/pee_back.sv =====
// Back end: stores tokens, checks counts, evaluates right to left on a stack.
// Depends on pee_pkg, pee_ram and pee_divider.
`timescale 1ns / 1ps

module pee_back #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  pee_pkg::q_item_t   tok_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int TW = $bits(pee_pkg::token_t);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b00000001,
    S_CHECK  = 8'b00000010,
    S_FETCH  = 8'b00000100,
    S_DECODE = 8'b00001000,
    S_OPER   = 8'b00010000,
    S_DIVW   = 8'b00100000,
    S_FINISH = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     ops;
  logic [CW-1:0]     opnds;
  logic              ovf;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     sp;
  logic [31:0]       top;
  pee_pkg::kind_t    op;
  pee_pkg::status_t  st;

  logic              tok_pop;
  logic              cnt_full;
  logic              sp_full;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     sp_m1;
  logic [CW-1:0]     sp_m2;
  logic [CW:0]       ops_p1;
  logic [TW-1:0]     buf_rdata;
  pee_pkg::token_t   dtok;
  logic [31:0]       opnd_val;
  logic              stk_we;
  logic [31:0]       rhs;
  logic [31:0]       prod;
  logic              div_start;
  logic              div_done;
  logic [31:0]       div_q;
  logic              result_load;

  assign tok_ready = (state == S_LOAD);
  assign tok_pop   = tok_valid && tok_ready;
  assign cnt_full  = (cnt == CW'(MAX_LEN));
  assign sp_full   = (sp == CW'(MAX_LEN));
  assign idx_m1    = idx - CW'(1);
  assign sp_m1     = sp - CW'(1);
  assign sp_m2     = sp - CW'(2);
  assign ops_p1    = {1'b0, ops} + (CW+1)'(1);
  assign dtok      = pee_pkg::token_t'(buf_rdata);
  assign opnd_val  = {24'd0, dtok.sym} - {24'd0, pee_pkg::CH_ZERO};
  assign prod      = top * rhs;

  // Old top moves into the stack memory when an operand is pushed
  assign stk_we = (state == S_DECODE) && (dtok.kind == pee_pkg::K_OPND) &&
                  !sp_full && (sp != '0);

  assign div_start = (state == S_OPER) && (op == pee_pkg::K_DIV) && (rhs != '0);
  assign result_load = (state == S_DONE) && (!out_valid || out_ready);

  // Character buffer
  pee_ram #(.WIDTH(TW), .DEPTH(MAX_LEN)) u_char_buf (
    .clk   (clk),
    .we    (tok_pop && !cnt_full),
    .waddr (cnt[AW-1:0]),
    .wdata (tok_data.tok),
    .raddr (idx_m1[AW-1:0]),
    .rdata (buf_rdata)
  );

  // Value stack below the top entry
  pee_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_m1[AW-1:0]),
    .wdata (top),
    .raddr (sp_m2[AW-1:0]),
    .rdata (rhs)
  );

  pee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      ops   <= '0;
      opnds <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (tok_pop) begin
            if (!cnt_full) begin
              cnt <= cnt + CW'(1);
              case (tok_data.tok.kind)
                pee_pkg::K_SPACE: ;
                pee_pkg::K_OPND:  opnds <= opnds + CW'(1);
                default:          ops <= ops + CW'(1);
              endcase
            end else begin
              ovf <= 1'b1;
            end
            if (tok_data.last) state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ovf) begin
            st    <= pee_pkg::ST_LONG;
            state <= S_DONE;
          end else if (ops_p1 != {1'b0, opnds}) begin
            st    <= pee_pkg::ST_COUNT;
            state <= S_DONE;
          end else begin
            idx   <= cnt;
            sp    <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (idx == '0) begin
            state <= S_FINISH;
          end else begin
            idx   <= idx_m1;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (dtok.kind)
            pee_pkg::K_SPACE: state <= S_FETCH;
            pee_pkg::K_OPND: begin
              if (sp_full) begin
                st    <= pee_pkg::ST_LONG;
                state <= S_DONE;
              end else begin
                top   <= opnd_val;
                sp    <= sp + CW'(1);
                state <= S_FETCH;
              end
            end
            default: begin
              if (sp < CW'(2)) begin
                st    <= pee_pkg::ST_UNDER;
                state <= S_DONE;
              end else begin
                op    <= dtok.kind;
                state <= S_OPER;
              end
            end
          endcase
        end
        S_OPER: begin
          // Pop two, push one
          case (op)
            pee_pkg::K_ADD: begin
              top   <= top + rhs;
              sp    <= sp_m1;
              state <= S_FETCH;
            end
            pee_pkg::K_SUB: begin
              top   <= top - rhs;
              sp    <= sp_m1;
              state <= S_FETCH;
            end
            pee_pkg::K_MUL: begin
              top   <= prod;
              sp    <= sp_m1;
              state <= S_FETCH;
            end
            default: begin
              if (rhs == '0) begin
                st    <= pee_pkg::ST_DIVZ;
                state <= S_DONE;
              end else begin
                sp    <= sp_m1;
                state <= S_DIVW;
              end
            end
          endcase
        end
        S_DIVW: begin
          if (div_done) begin
            top   <= div_q;
            state <= S_FETCH;
          end
        end
        S_FINISH: begin
          st    <= (sp == '0) ? pee_pkg::ST_UNDER : pee_pkg::ST_OK;
          state <= S_DONE;
        end
        S_DONE: begin
          if (result_load) begin
            cnt   <= '0;
            ops   <= '0;
            opnds <= '0;
            ovf   <= 1'b0;
            sp    <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      value  <= (st == pee_pkg::ST_OK) ? top : 32'sd0;
      status <= st;
    end
  end

endmodule

// ===== rtl/prefix_expression_evaluator.sv =====
// Prefix expression evaluator, top level: front end, token queue and back end.
// Depends on pee_pkg, pee_front and pee_back.
`timescale 1ns / 1ps

// One character is taken per transaction and loaded; the item with last set
// closes the expression. The back end then checks the operand and operator
// counts and walks the stored characters from right to left, one buffer read
// per character; a / waits on a divider that makes one quotient bit per
// cycle. The check, the end of the walk and the result load are states of
// their own. While the back end evaluates, characters of the next
// expression fill the two-entry queue and then input ready drops until the
// back end returns to loading. The result waits in an output register, so
// loading may resume before it is taken. Expressions longer than MAX_LEN
// characters report status 4.
module prefix_expression_evaluator #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         symbol,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  logic             tok_valid;
  logic             tok_ready;
  pee_pkg::q_item_t tok_data;

  pee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .symbol    (symbol),
    .last      (last),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

  pee_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

endmodule

// ===== rtl/pee_checker.sv =====
// Port-level checks for the prefix expression evaluator, bound to the top level.
// Depends on pee_pkg and prefix_expression_evaluator.
`timescale 1ns / 1ps

module pee_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         symbol,
  input logic               last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] value,
  input logic [2:0]         status
);

  // No result is pending right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A waiting input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(symbol) && $stable(last))
    else $error("stalled input changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("stalled result changed");

  // Failed evaluations report a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != pee_pkg::ST_OK) |-> (value == 32'sd0))
    else $error("nonzero value with error status");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pee_pkg::ST_OK) || (status == pee_pkg::ST_COUNT) ||
                  (status == pee_pkg::ST_UNDER) || (status == pee_pkg::ST_DIVZ) ||
                  (status == pee_pkg::ST_LONG))
    else $error("undefined status code");

endmodule

bind prefix_expression_evaluator pee_checker u_pee_checker (.*);
